FILE: rtl/lrr_pkg.sv
`timescale 1ns / 1ps

package lrr_pkg;

   localparam int ENTRIES = 8;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W  = IDX_W;

   localparam int FIELD_W = 3;

   typedef logic [1:0]         cmd_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [RANK_W-1:0]  rank_type;
   typedef logic [FIELD_W-1:0] field_type;

   localparam cmd_type CMD_TOUCH  = 2'd0;
   localparam cmd_type CMD_ALLOC  = 2'd1;
   localparam cmd_type CMD_DEMOTE = 2'd2;

endpackage

FILE: rtl/lru_rank_replacement.sv
`timescale 1ns / 1ps

// Recency-rank replacement policy for ENTRIES cache slots (rank 0 = least
// recently used). Each command (touch, allocate, demote, unused) returns one item
// with the chosen slot and its rank before the update. One command per
// cycle: an item is held in the input register, then the rank update and
// the result are computed in a single pass into the output register, for a
// throughput of one item per clock as long as the result side keeps up.
// Out-of-range slots and the unused command leave the ranks unchanged.
// After reset slot i holds rank i.
module lru_rank_replacement
   import lrr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [2:0] entry_index, [7:3] zero
   input  logic [1:0] req_tuser,   // [1:0] cmd

   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [2:0] slot_index, [5:3] old_rank, [7:6] zero
);

   logic      s1_valid_ff;
   logic      s1_valid_in;
   cmd_type   s1_cmd_ff;
   field_type s1_entry_ff;

   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   field_type rsp_slot_ff;
   field_type rsp_slot_in;
   field_type rsp_rank_ff;
   field_type rsp_rank_in;

   rank_type  rank_ff [ENTRIES];
   rank_type  rank_in [ENTRIES];

   logic      advance;

   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // Single pass: pick slot, read its rank, update every rank.
   always_comb begin
      logic     in_range;
      logic     is_alloc;
      logic     do_promote;
      logic     do_demote;
      idx_type  victim;
      idx_type  chosen;
      rank_type cur_rank;

      in_range = int'(s1_entry_ff) < ENTRIES;
      is_alloc = (s1_cmd_ff == CMD_ALLOC);

      // lowest slot holding rank 0; slot 0 if none
      victim = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (rank_ff[i] == '0) begin
            victim = IDX_W'(i);
         end
      end

      chosen = is_alloc ? victim : IDX_W'(s1_entry_ff);

      cur_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (IDX_W'(i) == chosen) begin
            cur_rank = cur_rank | rank_ff[i];
         end
      end

      do_promote = is_alloc || ((s1_cmd_ff == CMD_TOUCH) && in_range);
      do_demote  = (s1_cmd_ff == CMD_DEMOTE) && in_range;

      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (advance) begin
            if (do_promote) begin
               if (IDX_W'(i) == chosen) begin
                  rank_in[i] = RANK_W'(ENTRIES - 1);
               end else if (rank_ff[i] > cur_rank) begin
                  rank_in[i] = rank_ff[i] - rank_type'(1);
               end
            end else if (do_demote) begin
               if (IDX_W'(i) == chosen) begin
                  rank_in[i] = '0;
               end else if (rank_ff[i] < cur_rank) begin
                  rank_in[i] = rank_ff[i] + rank_type'(1);
               end
            end
         end
      end

      rsp_slot_in = is_alloc ? FIELD_W'(victim) : s1_entry_ff;
      rsp_rank_in = (is_alloc || in_range) ? FIELD_W'(cur_rank) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= RANK_W'(i);
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_cmd_ff   <= req_tuser;
         s1_entry_ff <= req_tdata[2:0];
      end
      if (advance) begin
         rsp_slot_ff <= rsp_slot_in;
         rsp_rank_ff <= rsp_rank_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_rank_ff, rsp_slot_ff};

endmodule

FILE: tb/lru_rank_replacement_test.sv
`timescale 1ns / 1ps

module lru_rank_replacement_test
   import lrr_pkg::*;
();

   localparam cmd_type CMD_UNUSED = 2'd3;
   localparam int      MAX_REPORTS = 10;

   typedef struct packed {
      field_type slot_index;
      field_type old_rank;
   } pick_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [2:0] entry_index, [7:3] zero
   logic [1:0] req_tuser;   // [1:0] cmd
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [2:0] slot_index, [5:3] old_rank, [7:6] zero

   rank_type   slot_rank [ENTRIES];
   pick_type   pending_picks[$];
   int         mismatch_count;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         stall_request;
   int         stall_left;

   lru_rank_replacement u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Recency ranks as the block should hold them, updated per accepted item.
   function automatic pick_type predict_pick(input cmd_type cmd, input field_type idx);
      pick_type pick;
      int       slot;
      rank_type r;
      bit       found;
      slot  = int'(idx);
      r     = '0;
      found = 1'b0;
      if (cmd == CMD_ALLOC) begin
         slot = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (!found && slot_rank[i] == '0) begin
               slot  = i;
               found = 1'b1;
            end
         end
      end
      if (cmd == CMD_ALLOC || (int'(idx) < ENTRIES)) begin
         r = slot_rank[slot];
         if (cmd == CMD_TOUCH || cmd == CMD_ALLOC) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_rank[i] > r) slot_rank[i] = slot_rank[i] - rank_type'(1);
            end
            slot_rank[slot] = rank_type'(ENTRIES - 1);
         end else if (cmd == CMD_DEMOTE) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_rank[i] < r) slot_rank[i] = slot_rank[i] + rank_type'(1);
            end
            slot_rank[slot] = '0;
         end
      end
      pick.slot_index = field_type'(slot);
      pick.old_rank   = field_type'(r);
      return pick;
   endfunction

   // Called right after a rising edge; leaves valid high so the next item can follow.
   task automatic send_cmd(input cmd_type cmd, input field_type idx);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, idx};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      pending_picks.push_back(predict_pick(cmd, idx));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_picks.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_pick(input logic [7:0] data);
      pick_type want;
      if (pending_picks.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("unexpected item: slot %0d rank %0d", data[2:0], data[5:3]);
      end else begin
         want = pending_picks.pop_front();
         if (data[2:0] !== want.slot_index || data[5:3] !== want.old_rank) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("mismatch: slot exp %0d got %0d, old_rank exp %0d got %0d",
                        want.slot_index, data[2:0], want.old_rank, data[5:3]);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_pick(rsp_tdata);
      if (stall_request > 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_cmd(CMD_TOUCH, 3'd0);     // LRU slot to the top
      send_cmd(CMD_TOUCH, 3'd0);     // already most recent
      send_cmd(CMD_TOUCH, 3'd7);
      send_cmd(CMD_ALLOC, 3'd0);
      send_cmd(CMD_ALLOC, 3'd7);     // index ignored on allocate
      send_cmd(CMD_DEMOTE, 3'd7);
      send_cmd(CMD_DEMOTE, 3'd7);    // already least recent
      send_cmd(CMD_ALLOC, 3'd5);     // victim is the demoted slot
      send_cmd(CMD_UNUSED, 3'd3);
      send_cmd(CMD_UNUSED, 3'd7);
      send_cmd(CMD_UNUSED, 3'd0);
      send_cmd(CMD_DEMOTE, 3'd0);
      send_cmd(CMD_TOUCH, 3'd5);
      send_cmd(CMD_DEMOTE, 3'd3);
      send_cmd(CMD_TOUCH, 3'd3);
      send_cmd(CMD_ALLOC, 3'd2);
      send_cmd(CMD_ALLOC, 3'd4);
      send_cmd(CMD_ALLOC, 3'd6);
      send_cmd(CMD_DEMOTE, 3'd1);
      send_cmd(CMD_TOUCH, 3'd6);
      wait_drained();
   endtask

   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      int      sel;
      cmd_type cmd;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         if (sel < 38)      cmd = CMD_TOUCH;
         else if (sel < 64) cmd = CMD_ALLOC;
         else if (sel < 92) cmd = CMD_DEMOTE;
         else               cmd = CMD_UNUSED;
         send_cmd(cmd, field_type'($urandom_range(7)));
      end
   endtask

   // Result side holds off while items keep coming, so the block backs up.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_request = 64;
      for (int n = 0; n < 40; n++)
         send_cmd(cmd_type'($urandom_range(2)), field_type'($urandom_range(7)));
      wait_drained();
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      rsp_tready     = 1'b0;
      mismatch_count = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      stall_request  = 0;
      stall_left     = 0;
      for (int i = 0; i < ENTRIES; i++) slot_rank[i] = rank_type'(i);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(270, 30, 83);
      wait_drained();
      test_backpressure();
      test_random(270, 83, 30);
      test_random(260, 0, 0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_picks.size() == 0) begin
         $display("[lru_rank_replacement] OK");
      end else begin
         $display("[lru_rank_replacement] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[lru_rank_replacement] ERROR");
      $finish;
   end

endmodule
